>>> sv/keypad_matrix_scan_decoder_macros.svh
// ----------------------------------------------------------------------------
// Keypad scan decoder assertion macros
// Concurrent check wrappers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_MATRIX_SCAN_DECODER_MACROS_SVH
`define KEYPAD_MATRIX_SCAN_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KMSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keypad scan decoder check failed");
// next-cycle implication
`define KMSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keypad scan decoder check failed");
`else
`define KMSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define KMSD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scan decoder package
// Shared types, event codes, key map constants and the character ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsd_pkg;

   localparam int MESSAGE_CAPACITY = 120;
   localparam logic [6:0] MSG_LEN_MAX = 7'(MESSAGE_CAPACITY - 1);

   localparam logic [15:0] DWELL_RESET   = 16'd5;
   localparam logic [15:0] LOCKOUT_RESET = 16'd200;

   // configuration register indexes
   localparam logic [1:0] REG_DWELL   = 2'd0;
   localparam logic [1:0] REG_LOCKOUT = 2'd1;
   localparam logic [1:0] REG_READY   = 2'd2;

   typedef enum logic [3:0] {
      EV_NONE  = 4'd0,
      EV_CHAR  = 4'd1,
      EV_BACK  = 4'd2,
      EV_UP    = 4'd3,
      EV_DOWN  = 4'd4,
      EV_READY = 4'd5,
      EV_SHIFT = 4'd6,
      EV_ACK   = 4'd7,
      EV_SEND  = 4'd8
   } kmsd_event_type;

   // shift modes
   localparam logic [1:0] SHIFT_LOWER = 2'd0;
   localparam logic [1:0] SHIFT_UPPER = 2'd1;
   localparam logic [1:0] SHIFT_CAPS  = 2'd2;

   // function row key columns
   localparam logic [2:0] FKEY_UP    = 3'd0;
   localparam logic [2:0] FKEY_READY = 3'd1;
   localparam logic [2:0] FKEY_DOWN  = 3'd2;
   localparam logic [2:0] FKEY_BACK  = 3'd4;
   localparam logic [2:0] FKEY_SHIFT = 3'd5;
   localparam logic [2:0] FKEY_ACK   = 3'd6;
   localparam logic [2:0] FKEY_SEND  = 3'd7;

   typedef struct packed {
      logic [15:0] dwell_ticks;
      logic [15:0] lockout_ticks;
      logic        ready_enabled;
   } kmsd_cfg_type;

   typedef struct packed {
      logic [7:0]     column_drive;
      kmsd_event_type event_kind;
      logic [7:0]     char_code;
      logic [1:0]     shift_mode;
      logic           ready_confirmed;
      logic [6:0]     message_length;
      logic           send_ready;
   } kmsd_result_type;

   localparam logic [7:0] ROM_LOWER [32] = '{
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h3F, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67,
      8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h26, 8'h7A, 8'h78, 8'h63,
      8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h20, 8'h20
   };

   localparam logic [7:0] ROM_UPPER [32] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h2B, 8'h21, 8'h22, 8'h9C,
      8'h24, 8'h25, 8'h27, 8'h3A, 8'h2A, 8'h28, 8'h29, 8'h43,
      8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h20, 8'h20
   };

   localparam logic [7:0] ROM_CAPS [32] = '{
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h3F, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47,
      8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h26, 8'h5A, 8'h58, 8'h43,
      8'h56, 8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h20, 8'h20
   };

   // unused mode code falls back to the lower case table
   function automatic logic [7:0] char_rom(input logic [1:0] mode, input logic [4:0] addr);
      logic [7:0] code;
      case (mode)
         SHIFT_UPPER: code = ROM_UPPER[addr];
         SHIFT_CAPS:  code = ROM_CAPS[addr];
         default:     code = ROM_LOWER[addr];
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> sv/keypad_matrix_scan_decoder.sv
// ----------------------------------------------------------------------------
// Keypad matrix scan decoder
// Stages: input register, decode, result register. An accepted req transaction
// passes through them in that order, and the result register drives rsp_tvalid.
// Throughput: one tick per cycle unless stalled by rsp_tready.
// Reset: synchronous; valid flags, config and core state return to their defaults, scan restarts at
// the first column, and the message state clears.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypad_matrix_scan_decoder_macros.svh"

module keypad_matrix_scan_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [4:0] row_lines, [7:5] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] column_drive, [15:8] char_code,
                                         // [17:16] shift_mode, [18] ready_confirmed,
                                         // [25:19] message_length, [26] send_ready,
                                         // [31:27] zero
   output logic [3:0]       rsp_tuser,   // [3:0] event_kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import kmsd_pkg::*;

   kmsd_cfg_type    cfg_ff;
   logic            in_valid_ff, in_valid_in;
   logic [4:0]      rows_ff;
   logic            out_valid_ff, out_valid_in;
   kmsd_result_type out_ff;
   kmsd_result_type result;
   logic            out_free;
   logic            advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dwell_ticks   <= DWELL_RESET;
         cfg_ff.lockout_ticks <= LOCKOUT_RESET;
         cfg_ff.ready_enabled <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DWELL:   cfg_ff.dwell_ticks   <= csr_data;
            REG_LOCKOUT: cfg_ff.lockout_ticks <= csr_data;
            REG_READY:   cfg_ff.ready_enabled <= csr_data[0];
            default:     ;
         endcase
      end
   end

   // result register frees when empty or being drained
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         rows_ff <= req_tdata[4:0];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   kmsd_scan_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .row_lines (rows_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.event_kind;
   assign rsp_tdata  = {5'd0, out_ff.send_ready, out_ff.message_length,
                        out_ff.ready_confirmed, out_ff.shift_mode,
                        out_ff.char_code, out_ff.column_drive};

   `KMSD_ASSERT_IMP(a_column_onehot, clock, reset, rsp_tvalid, $onehot(rsp_tdata[7:0]))
   `KMSD_ASSERT_IMP(a_send_ready_len, clock, reset, rsp_tvalid,
                    rsp_tdata[26] == (rsp_tdata[25:19] != 7'd0))
   `KMSD_ASSERT_IMP(a_char_only_on_char, clock, reset,
                    rsp_tvalid && (rsp_tuser != EV_CHAR), rsp_tdata[15:8] == 8'd0)
   `KMSD_ASSERT_NXT(a_len_bounded, clock, reset, advance,
                    rsp_tvalid && (rsp_tdata[25:19] <= MSG_LEN_MAX))

endmodule

`default_nettype wire

>>> sv/kmsd_scan_core.sv
// ----------------------------------------------------------------------------
// Keypad scan core
// Column scan, edge detect with lockout, key decode and message state.
// State moves one tick each time the input stage hands over a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsd_scan_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic [4:0]               row_lines,
   input  wire kmsd_pkg::kmsd_cfg_type   cfg,
   output kmsd_pkg::kmsd_result_type     result
);
   import kmsd_pkg::*;

   logic [2:0]  col_ff,     col_in;
   logic [15:0] dwell_ff,   dwell_in;
   logic [15:0] lockout_ff, lockout_in;
   logic [4:0]  prev_ff;
   logic [1:0]  shift_ff,   shift_in;
   logic        toggle_ff,  toggle_in;
   logic [6:0]  length_ff,  length_in;

   logic [4:0]     rising;
   logic [1:0]     char_row;
   logic           fkey_row;
   kmsd_event_type kind;
   logic [7:0]     code;
   logic [16:0]    dwell_sum;
   logic [15:0]    dwell_lim;

   assign rising = row_lines & ~prev_ff;

   // lowest rising row wins
   always_comb begin
      char_row = 2'd0;
      fkey_row = 1'b0;
      if (rising[0]) begin
         char_row = 2'd0;
      end else if (rising[1]) begin
         char_row = 2'd1;
      end else if (rising[2]) begin
         char_row = 2'd2;
      end else if (rising[3]) begin
         char_row = 2'd3;
      end else begin
         fkey_row = 1'b1;
      end
   end

   always_comb begin
      kind       = EV_NONE;
      code       = 8'd0;
      lockout_in = lockout_ff;
      shift_in   = shift_ff;
      toggle_in  = toggle_ff;
      length_in  = length_ff;
      if (lockout_ff != 16'd0) begin
         lockout_in = lockout_ff - 16'd1;
      end else if (rising != 5'd0) begin
         if (!fkey_row) begin
            kind = EV_CHAR;
            code = char_rom(shift_ff, {char_row, col_ff});
            if (length_ff < MSG_LEN_MAX) begin
               length_in = length_ff + 7'd1;
            end
         end else begin
            case (col_ff)
               FKEY_UP:    kind = EV_UP;
               FKEY_READY: begin
                  kind      = EV_READY;
                  toggle_in = ~toggle_ff;
               end
               FKEY_DOWN:  kind = EV_DOWN;
               FKEY_BACK:  begin
                  kind = EV_BACK;
                  if (length_ff != 7'd0) begin
                     length_in = length_ff - 7'd1;
                  end
               end
               FKEY_SHIFT: begin
                  kind = EV_SHIFT;
                  case (shift_ff)
                     SHIFT_LOWER: shift_in = SHIFT_UPPER;
                     SHIFT_UPPER: shift_in = SHIFT_CAPS;
                     default:     shift_in = SHIFT_LOWER;
                  endcase
               end
               FKEY_ACK:   kind = EV_ACK;
               FKEY_SEND:  begin
                  kind      = EV_SEND;
                  length_in = 7'd0;
               end
               default:    kind = EV_NONE;
            endcase
         end
         if (kind != EV_NONE) begin
            lockout_in = cfg.lockout_ticks;
         end
      end
   end

   // a zero dwell setting behaves as one
   assign dwell_lim = (cfg.dwell_ticks == 16'd0) ? 16'd1 : cfg.dwell_ticks;
   assign dwell_sum = {1'b0, dwell_ff} + 17'd1;

   always_comb begin
      if (dwell_sum >= {1'b0, dwell_lim}) begin
         dwell_in = 16'd0;
         col_in   = col_ff + 3'd1;
      end else begin
         dwell_in = dwell_sum[15:0];
         col_in   = col_ff;
      end
   end

   always_comb begin
      result.column_drive    = 8'd1 << col_ff;
      result.event_kind      = kind;
      result.char_code       = code;
      result.shift_mode      = shift_in;
      result.ready_confirmed = toggle_in & cfg.ready_enabled;
      result.message_length  = length_in;
      result.send_ready      = (length_in != 7'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= 3'd0;
         dwell_ff   <= 16'd0;
         lockout_ff <= 16'd0;
         prev_ff    <= 5'd0;
         shift_ff   <= SHIFT_LOWER;
         toggle_ff  <= 1'b0;
         length_ff  <= 7'd0;
      end else if (advance) begin
         col_ff     <= col_in;
         dwell_ff   <= dwell_in;
         lockout_ff <= lockout_in;
         prev_ff    <= row_lines;
         shift_ff   <= shift_in;
         toggle_ff  <= toggle_in;
         length_ff  <= length_in;
      end
   end

endmodule

`default_nettype wire
